FILE: rtl/assert_macros.svh
// assertion macros for the property checker fscc_props
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, quiet while rst_n is low
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, quiet while rst_n is low
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/fscc_pkg.sv
package fscc_pkg;

  // fixed field widths
  localparam int IN_W     = 11;
  localparam int SUM_W    = 32;
  localparam int NCOND_MX = 8;
  localparam int CODE_W   = 3;
  localparam int SLOT_W   = NCOND_MX * CODE_W;
  localparam int PAIR_W   = 2 * SLOT_W;
  localparam int NUM_PAIR = 4;
  localparam int DATA_W   = 64;
  localparam int ADDR_W   = 6;
  localparam int IDX_W    = 3;
  localparam int CNT_W    = 4;
  localparam int MASK_W   = 8;

  // condition codes
  localparam logic [CODE_W-1:0] CODE_ABSENT = 3'd0;
  localparam logic [CODE_W-1:0] CODE_NEGATE = 3'd1;

  // register map, one 64-bit slot per register
  typedef enum logic [IDX_W-1:0] {
    REG_PAIR_0     = 3'd0,
    REG_PAIR_1     = 3'd1,
    REG_PAIR_2     = 3'd2,
    REG_PAIR_3     = 3'd3,
    REG_FUZZY_MASK = 3'd4,
    REG_IMP_COUNT  = 3'd5,
    REG_CONS_THR   = 3'd6,
    REG_COV_THR    = 3'd7
  } reg_idx_t;

  typedef logic [IN_W-1:0] raw_t;
  typedef logic [PAIR_W-1:0] pair_t;

  // per-stage control
  typedef struct packed {
    logic valid;
    logic last;
  } fscc_ctl_t;

  // sums handed from the accumulator to the check stage
  typedef struct packed {
    logic [SUM_W-1:0] x;
    logic [SUM_W-1:0] xy;
    logic [SUM_W-1:0] y;
  } fscc_totals_t;

endpackage

FILE: rtl/fscc_if.sv
// row channel
interface fscc_in_if;
  logic              valid;
  logic              ready;
  fscc_pkg::raw_t    cond_0;
  fscc_pkg::raw_t    cond_1;
  fscc_pkg::raw_t    cond_2;
  fscc_pkg::raw_t    cond_3;
  fscc_pkg::raw_t    cond_4;
  fscc_pkg::raw_t    cond_5;
  fscc_pkg::raw_t    cond_6;
  fscc_pkg::raw_t    cond_7;
  fscc_pkg::raw_t    outcome;
  logic              last_row;

  modport source (
    output valid, cond_0, cond_1, cond_2, cond_3, cond_4, cond_5, cond_6, cond_7,
           outcome, last_row,
    input  ready
  );
  modport sink (
    input  valid, cond_0, cond_1, cond_2, cond_3, cond_4, cond_5, cond_6, cond_7,
           outcome, last_row,
    output ready
  );
endinterface

// result channel
interface fscc_out_if;
  logic                           valid;
  logic                           ready;
  logic                           solution_ok;
  logic                           consistency_ok;
  logic                           coverage_ok;
  logic [fscc_pkg::SUM_W-1:0]     total_x;
  logic [fscc_pkg::SUM_W-1:0]     total_xy;
  logic [fscc_pkg::SUM_W-1:0]     total_y;

  modport source (
    output valid, solution_ok, consistency_ok, coverage_ok, total_x, total_xy, total_y,
    input  ready
  );
  modport sink (
    input  valid, solution_ok, consistency_ok, coverage_ok, total_x, total_xy, total_y,
    output ready
  );
endinterface

FILE: rtl/fscc_lane.sv
module fscc_lane #(
  parameter int NUM_CONDITIONS = 8,
  parameter int FRAC_BITS      = 10
) (
  input  logic                                                   clk,
  input  logic                                                   load,
  input  logic                                                   en,
  input  logic [fscc_pkg::SLOT_W-1:0]                            slot,
  input  logic [fscc_pkg::MASK_W-1:0]                            fuzzy_mask,
  input  logic [fscc_pkg::NCOND_MX-1:0][fscc_pkg::IN_W-1:0]      cond,
  output logic [FRAC_BITS:0]                                     memb
);
  import fscc_pkg::*;

  localparam int MW = FRAC_BITS + 1;
  localparam int CW = (MW > IN_W) ? MW : IN_W;
  localparam logic [CW-1:0] ONE_C = CW'(1) << FRAC_BITS;

  logic [MW-1:0] memb_r;
  logic [MW-1:0] memb_nxt;

  // min over the present conditions of this implicant
  always_comb begin
    logic [CODE_W-1:0] code;
    logic [CW-1:0]     raw;
    logic [CW-1:0]     v;
    logic [MW-1:0]     t;
    logic [MW-1:0]     m;
    m = MW'(ONE_C);
    for (int c = 0; c < NUM_CONDITIONS; c++) begin
      code = slot[c*CODE_W +: CODE_W];
      raw  = CW'(cond[c]);
      v    = (raw > ONE_C) ? ONE_C : raw;
      if (fuzzy_mask[c]) begin
        t = (code == CODE_NEGATE) ? MW'(ONE_C - v) : MW'(v);
      end else begin
        t = (raw == CW'(code - CODE_W'(1))) ? MW'(ONE_C) : '0;
      end
      if (code != CODE_ABSENT && t < m) begin
        m = t;
      end
    end
    // an unused implicant never wins the max
    memb_nxt = en ? m : '0;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      memb_r <= memb_nxt;
    end
  end

  assign memb = memb_r;

endmodule

FILE: rtl/fscc_merge.sv
module fscc_merge #(
  parameter int MAX_IMPLICANTS = 8,
  parameter int FRAC_BITS      = 10
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  fscc_pkg::fscc_ctl_t                         in_ctl,
  input  logic [MAX_IMPLICANTS-1:0][FRAC_BITS:0]      memb,
  input  fscc_pkg::raw_t                              outcome,
  input  logic                                        down_ready,
  output logic                                        up_ready,
  output fscc_pkg::fscc_ctl_t                         out_ctl,
  output logic [FRAC_BITS:0]                          x,
  output logic [FRAC_BITS:0]                          xy,
  output logic [FRAC_BITS:0]                          y
);
  import fscc_pkg::*;

  localparam int MW = FRAC_BITS + 1;
  localparam int CW = (MW > IN_W) ? MW : IN_W;
  localparam logic [CW-1:0] ONE_C = CW'(1) << FRAC_BITS;

  fscc_ctl_t     ctl_r;
  logic [MW-1:0] x_r, xy_r, y_r;
  logic [MW-1:0] x_nxt, xy_nxt, y_nxt;
  logic [CW-1:0] y_raw;

  // solution membership: max over the lanes
  always_comb begin
    x_nxt = '0;
    for (int i = 0; i < MAX_IMPLICANTS; i++) begin
      if (memb[i] > x_nxt) begin
        x_nxt = memb[i];
      end
    end
  end

  // clamped outcome and the overlap term
  assign y_raw  = CW'(outcome);
  assign y_nxt  = (y_raw > ONE_C) ? MW'(ONE_C) : MW'(y_raw);
  assign xy_nxt = (x_nxt < y_nxt) ? x_nxt : y_nxt;

  assign up_ready = !ctl_r.valid || down_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (up_ready) begin
      ctl_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && in_ctl.valid) begin
      x_r  <= x_nxt;
      xy_r <= xy_nxt;
      y_r  <= y_nxt;
    end
  end

  assign out_ctl = ctl_r;
  assign x       = x_r;
  assign xy      = xy_r;
  assign y       = y_r;

endmodule

FILE: rtl/fscc_accum.sv
module fscc_accum #(
  parameter int FRAC_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  fscc_pkg::fscc_ctl_t    in_ctl,
  input  logic [FRAC_BITS:0]     x,
  input  logic [FRAC_BITS:0]     xy,
  input  logic [FRAC_BITS:0]     y,
  input  logic                   down_ready,
  output logic                   up_ready,
  output logic                   tot_valid,
  output fscc_pkg::fscc_totals_t totals
);
  import fscc_pkg::*;

  logic [SUM_W-1:0] acc_x_r, acc_xy_r, acc_y_r;
  logic [SUM_W-1:0] sum_x, sum_xy, sum_y;
  fscc_totals_t     totals_r;
  logic             tot_valid_r;
  logic             tot_valid_nxt;
  logic             take;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? '1 : s[SUM_W-1:0];
  endfunction

  assign sum_x  = sat_add(acc_x_r, SUM_W'(x));
  assign sum_xy = sat_add(acc_xy_r, SUM_W'(xy));
  assign sum_y  = sat_add(acc_y_r, SUM_W'(y));

  // plain rows never wait; a last row needs the totals slot
  assign up_ready = !tot_valid_r || down_ready || !in_ctl.last;
  assign take     = in_ctl.valid && up_ready;

  always_comb begin
    if (take && in_ctl.last) begin
      tot_valid_nxt = 1'b1;
    end else if (down_ready) begin
      tot_valid_nxt = 1'b0;
    end else begin
      tot_valid_nxt = tot_valid_r;
    end
  end

  // running sums, cleared after the last row of a set
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_x_r     <= '0;
      acc_xy_r    <= '0;
      acc_y_r     <= '0;
      tot_valid_r <= 1'b0;
    end else begin
      tot_valid_r <= tot_valid_nxt;
      if (take) begin
        if (in_ctl.last) begin
          acc_x_r  <= '0;
          acc_xy_r <= '0;
          acc_y_r  <= '0;
        end else begin
          acc_x_r  <= sum_x;
          acc_xy_r <= sum_xy;
          acc_y_r  <= sum_y;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_ctl.last) begin
      totals_r.x  <= sum_x;
      totals_r.xy <= sum_xy;
      totals_r.y  <= sum_y;
    end
  end

  assign tot_valid = tot_valid_r;
  assign totals    = totals_r;

endmodule

FILE: rtl/fscc_check.sv
module fscc_check #(
  parameter int FRAC_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   tot_valid,
  input  fscc_pkg::fscc_totals_t totals,
  input  fscc_pkg::raw_t         cons_thr,
  input  fscc_pkg::raw_t         cov_thr,
  output logic                   up_ready,
  fscc_out_if.source             out_ch
);
  import fscc_pkg::*;

  localparam int MW = FRAC_BITS + 1;
  localparam int PW = SUM_W + ((MW > IN_W) ? MW : IN_W);

  // product stage
  logic             prod_valid_r;
  logic [PW-1:0]    lhs_r, cons_r, cov_r;
  fscc_totals_t     prod_tot_r;
  logic [PW-1:0]    lhs_nxt, cons_nxt, cov_nxt;

  // result register
  logic             res_valid_r;
  logic             cons_ok_r, cov_ok_r;
  fscc_totals_t     res_tot_r;
  logic             cons_ok_nxt, cov_ok_nxt;
  logic             res_ready;

  assign lhs_nxt  = PW'(totals.xy) << FRAC_BITS;
  assign cons_nxt = PW'(cons_thr) * PW'(totals.x);
  assign cov_nxt  = PW'(cov_thr) * PW'(totals.y);

  assign res_ready = !res_valid_r || out_ch.ready;
  assign up_ready  = !prod_valid_r || res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
    end else if (up_ready) begin
      prod_valid_r <= tot_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && tot_valid) begin
      lhs_r      <= lhs_nxt;
      cons_r     <= cons_nxt;
      cov_r      <= cov_nxt;
      prod_tot_r <= totals;
    end
  end

  // exact ratio compares, a zero denominator fails
  assign cons_ok_nxt = (prod_tot_r.x != '0) && (lhs_r >= cons_r);
  assign cov_ok_nxt  = (prod_tot_r.y != '0) && (lhs_r >= cov_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (res_ready) begin
      res_valid_r <= prod_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && prod_valid_r) begin
      cons_ok_r <= cons_ok_nxt;
      cov_ok_r  <= cov_ok_nxt;
      res_tot_r <= prod_tot_r;
    end
  end

  assign out_ch.valid          = res_valid_r;
  assign out_ch.solution_ok    = cons_ok_r && cov_ok_r;
  assign out_ch.consistency_ok = cons_ok_r;
  assign out_ch.coverage_ok    = cov_ok_r;
  assign out_ch.total_x        = res_tot_r.x;
  assign out_ch.total_xy       = res_tot_r.xy;
  assign out_ch.total_y        = res_tot_r.y;

endmodule

FILE: rtl/fuzzy_solution_consistency_check.sv
// Fuzzy solution consistency and coverage check. Takes one data row per clock
// unless stalled by back-pressure (eight Q1.10 condition values, an outcome and
// a last-row flag), evaluates up to eight implicants in parallel lanes, takes
// their max as the solution membership x, and keeps saturating 32-bit sums of
// x, min(x,y) and y. A last row yields one result word with the pass flags and
// the three sums, then the sums restart from zero; other rows yield nothing.
// Rows are taken every cycle while in_ch.ready is high; a result word passes the
// lane, merge, accumulate, multiply and compare registers in that order after
// its last row is accepted, each stage having its own valid bit so bubbles fill
// while the output word waits. The 11x32 threshold products set the critical
// path. Registers sit on a 64-bit APB port at byte address 8*i: implicant pairs
// 0..3, fuzzy mask, implicant count, consistency threshold, coverage threshold;
// write them only while no row is in flight.
module fuzzy_solution_consistency_check #(
  parameter int NUM_CONDITIONS = 8,
  parameter int MAX_IMPLICANTS = 8,
  parameter int FRAC_BITS      = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  fscc_in_if.sink                         in_ch,
  fscc_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fscc_pkg::ADDR_W-1:0]     paddr,
  input  logic [fscc_pkg::DATA_W-1:0]     pwdata,
  output logic [fscc_pkg::DATA_W-1:0]     prdata,
  output logic                            pready
);
  import fscc_pkg::*;

  localparam int MW = FRAC_BITS + 1;

  // configuration registers
  pair_t               pair_r [NUM_PAIR];
  logic [MASK_W-1:0]   fuzzy_mask_r;
  logic [CNT_W-1:0]    imp_count_r;
  raw_t                cons_thr_r;
  raw_t                cov_thr_r;
  reg_idx_t            reg_idx;
  logic                wr_en;

  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1 -: IDX_W]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_PAIR; p++) begin
        pair_r[p] <= '0;
      end
      fuzzy_mask_r <= '0;
      imp_count_r  <= CNT_W'(1);
      cons_thr_r   <= '0;
      cov_thr_r    <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PAIR_0:     pair_r[0]    <= pwdata[PAIR_W-1:0];
        REG_PAIR_1:     pair_r[1]    <= pwdata[PAIR_W-1:0];
        REG_PAIR_2:     pair_r[2]    <= pwdata[PAIR_W-1:0];
        REG_PAIR_3:     pair_r[3]    <= pwdata[PAIR_W-1:0];
        REG_FUZZY_MASK: fuzzy_mask_r <= pwdata[MASK_W-1:0];
        REG_IMP_COUNT:  imp_count_r  <= pwdata[CNT_W-1:0];
        REG_CONS_THR:   cons_thr_r   <= pwdata[IN_W-1:0];
        REG_COV_THR:    cov_thr_r    <= pwdata[IN_W-1:0];
        default:        ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      REG_PAIR_0:     prdata = DATA_W'(pair_r[0]);
      REG_PAIR_1:     prdata = DATA_W'(pair_r[1]);
      REG_PAIR_2:     prdata = DATA_W'(pair_r[2]);
      REG_PAIR_3:     prdata = DATA_W'(pair_r[3]);
      REG_FUZZY_MASK: prdata = DATA_W'(fuzzy_mask_r);
      REG_IMP_COUNT:  prdata = DATA_W'(imp_count_r);
      REG_CONS_THR:   prdata = DATA_W'(cons_thr_r);
      REG_COV_THR:    prdata = DATA_W'(cov_thr_r);
      default:        prdata = '0;
    endcase
  end

  // number of lanes in use, capped at the lane count
  logic [CNT_W-1:0] n_eff;
  assign n_eff = (imp_count_r > CNT_W'(MAX_IMPLICANTS)) ? CNT_W'(MAX_IMPLICANTS)
                                                        : imp_count_r;

  // input word
  logic [NCOND_MX-1:0][IN_W-1:0] cond;
  assign cond[0] = in_ch.cond_0;
  assign cond[1] = in_ch.cond_1;
  assign cond[2] = in_ch.cond_2;
  assign cond[3] = in_ch.cond_3;
  assign cond[4] = in_ch.cond_4;
  assign cond[5] = in_ch.cond_5;
  assign cond[6] = in_ch.cond_6;
  assign cond[7] = in_ch.cond_7;

  // lane stage control
  fscc_ctl_t s1_ctl_r;
  raw_t      s1_outcome_r;
  logic      mrg_ready;
  logic      load;

  assign in_ch.ready = !s1_ctl_r.valid || mrg_ready;
  assign load        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
    end else if (in_ch.ready) begin
      s1_ctl_r.valid <= in_ch.valid;
      s1_ctl_r.last  <= in_ch.last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_outcome_r <= in_ch.outcome;
    end
  end

  // one lane per implicant
  logic [MAX_IMPLICANTS-1:0][MW-1:0] memb;

  for (genvar i = 0; i < MAX_IMPLICANTS; i++) begin : g_lane
    fscc_lane #(
      .NUM_CONDITIONS (NUM_CONDITIONS),
      .FRAC_BITS      (FRAC_BITS)
    ) u_lane (
      .clk        (clk),
      .load       (load),
      .en         (CNT_W'(i) < n_eff),
      .slot       (pair_r[i/2][(i%2)*SLOT_W +: SLOT_W]),
      .fuzzy_mask (fuzzy_mask_r),
      .cond       (cond),
      .memb       (memb[i])
    );
  end

  // merge of the lanes
  fscc_ctl_t     s2_ctl;
  logic [MW-1:0] s2_x, s2_xy, s2_y;
  logic          acc_ready;

  fscc_merge #(
    .MAX_IMPLICANTS (MAX_IMPLICANTS),
    .FRAC_BITS      (FRAC_BITS)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ctl     (s1_ctl_r),
    .memb       (memb),
    .outcome    (s1_outcome_r),
    .down_ready (acc_ready),
    .up_ready   (mrg_ready),
    .out_ctl    (s2_ctl),
    .x          (s2_x),
    .xy         (s2_xy),
    .y          (s2_y)
  );

  // running sums
  logic         tot_valid;
  fscc_totals_t totals;
  logic         chk_ready;

  fscc_accum #(
    .FRAC_BITS (FRAC_BITS)
  ) u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ctl     (s2_ctl),
    .x          (s2_x),
    .xy         (s2_xy),
    .y          (s2_y),
    .down_ready (chk_ready),
    .up_ready   (acc_ready),
    .tot_valid  (tot_valid),
    .totals     (totals)
  );

  // threshold checks and result word
  fscc_check #(
    .FRAC_BITS (FRAC_BITS)
  ) u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .tot_valid (tot_valid),
    .totals    (totals),
    .cons_thr  (cons_thr_r),
    .cov_thr   (cov_thr_r),
    .up_ready  (chk_ready),
    .out_ch    (out_ch)
  );

endmodule

FILE: rtl/fscc_props.sv
`include "assert_macros.svh"

module fscc_props (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         solution_ok,
  input logic                         consistency_ok,
  input logic                         coverage_ok,
  input logic [fscc_pkg::SUM_W-1:0]   total_x,
  input logic [fscc_pkg::SUM_W-1:0]   total_xy,
  input logic [fscc_pkg::SUM_W-1:0]   total_y
);

  // overall flag is the and of both checks
  `ASSERT_IMPLY(a_sol_and, out_valid, solution_ok == (consistency_ok && coverage_ok), "solution_ok mismatch")

  // a passing check never has a zero denominator
  `ASSERT_IMPLY(a_cons_nz, out_valid && consistency_ok, total_x != '0, "consistency passed on zero sum_x")
  `ASSERT_IMPLY(a_cov_nz, out_valid && coverage_ok, total_y != '0, "coverage passed on zero sum_y")

  // overlap sum is bounded by both other sums
  `ASSERT_IMPLY(a_xy_bound, out_valid, (total_xy <= total_x) && (total_xy <= total_y), "total_xy exceeds a bound")

  // a stalled result word stays offered
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

endmodule

bind fuzzy_solution_consistency_check fscc_props u_fscc_props (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .solution_ok    (out_ch.solution_ok),
  .consistency_ok (out_ch.consistency_ok),
  .coverage_ok    (out_ch.coverage_ok),
  .total_x        (out_ch.total_x),
  .total_xy       (out_ch.total_xy),
  .total_y        (out_ch.total_y)
);

FILE: sim/fscc_verdict_checker.sv
`timescale 1ns / 1ps

module fscc_verdict_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  fscc_in_if                          rows,
  fscc_out_if                         verdicts,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fscc_pkg::ADDR_W-1:0] paddr,
  input  logic [fscc_pkg::DATA_W-1:0] pwdata,
  input  logic                        pready,
  output int                          fail_count,
  output int                          verdicts_due
);
  import fscc_pkg::*;

  localparam int            FRAC_BITS = 10;
  localparam int            IMP_MAX   = 8;
  localparam logic [IN_W-1:0] FULL    = 11'd1024;

  typedef logic [NCOND_MX-1:0][IN_W-1:0] cond_vec_t;

  typedef struct packed {
    logic             solution_ok;
    logic             consistency_ok;
    logic             coverage_ok;
    logic [SUM_W-1:0] total_x;
    logic [SUM_W-1:0] total_xy;
    logic [SUM_W-1:0] total_y;
  } verdict_t;

  // shadow of the register file
  pair_t             pair_reg [NUM_PAIR];
  logic [MASK_W-1:0] mask_reg;
  logic [CNT_W-1:0]  count_reg;
  logic [IN_W-1:0]   cons_reg;
  logic [IN_W-1:0]   cov_reg;

  // running sums of the current data set
  logic [SUM_W-1:0]  sum_x;
  logic [SUM_W-1:0]  sum_xy;
  logic [SUM_W-1:0]  sum_y;

  verdict_t          due_verdicts [$];
  int                shown;

  function automatic logic [IN_W-1:0] clip_full(logic [IN_W-1:0] v);
    return (v > FULL) ? FULL : v;
  endfunction

  function automatic logic [SUM_W-1:0] add_sat(logic [SUM_W-1:0] a, logic [IN_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + b;
    return s[SUM_W] ? '1 : s[SUM_W-1:0];
  endfunction

  // membership of one implicant: min over its present condition terms
  function automatic logic [IN_W-1:0] implicant_degree(int imp, cond_vec_t cv);
    logic [SLOT_W-1:0] slot;
    logic [CODE_W-1:0] code;
    logic [IN_W-1:0]   term;
    logic [IN_W-1:0]   deg;
    slot = imp[0] ? pair_reg[imp >> 1][PAIR_W-1:SLOT_W] : pair_reg[imp >> 1][SLOT_W-1:0];
    deg  = FULL;
    for (int c = 0; c < NCOND_MX; c++) begin
      code = slot[CODE_W*c +: CODE_W];
      if (code != CODE_ABSENT) begin
        if (mask_reg[c]) begin
          term = (code == CODE_NEGATE) ? FULL - clip_full(cv[c]) : clip_full(cv[c]);
        end else begin
          // crisp level equality
          term = (int'(cv[c]) == int'(code) - 1) ? FULL : '0;
        end
        if (term < deg) deg = term;
      end
    end
    return deg;
  endfunction

  // fold one row into the sums, queue a verdict on the last row
  function automatic void fold_row(cond_vec_t cv, logic [IN_W-1:0] outc, logic last);
    int              n;
    logic [IN_W-1:0] x;
    logic [IN_W-1:0] y;
    logic [IN_W-1:0] m;
    logic [IN_W-1:0] xy;
    logic [63:0]     lhs;
    verdict_t        v;
    n = (count_reg > IMP_MAX) ? IMP_MAX : int'(count_reg);
    x = '0;
    for (int i = 0; i < n; i++) begin
      m = implicant_degree(i, cv);
      if (m > x) x = m;
    end
    y  = clip_full(outc);
    xy = (x < y) ? x : y;
    sum_x  = add_sat(sum_x, x);
    sum_xy = add_sat(sum_xy, xy);
    sum_y  = add_sat(sum_y, y);
    if (last) begin
      lhs = {32'd0, sum_xy} << FRAC_BITS;
      v.consistency_ok = (sum_x != 0) && (lhs >= {53'd0, cons_reg} * {32'd0, sum_x});
      v.coverage_ok    = (sum_y != 0) && (lhs >= {53'd0, cov_reg} * {32'd0, sum_y});
      v.solution_ok    = v.consistency_ok && v.coverage_ok;
      v.total_x        = sum_x;
      v.total_xy       = sum_xy;
      v.total_y        = sum_y;
      due_verdicts.push_back(v);
      sum_x  = '0;
      sum_xy = '0;
      sum_y  = '0;
    end
  endfunction

  always @(posedge clk) begin
    reg_idx_t  idx;
    verdict_t  want;
    verdict_t  got;
    if (!rst_n) begin
      for (int p = 0; p < NUM_PAIR; p++) pair_reg[p] = '0;
      mask_reg  = '0;
      count_reg = 4'd1;
      cons_reg  = '0;
      cov_reg   = '0;
      sum_x     = '0;
      sum_xy    = '0;
      sum_y     = '0;
      due_verdicts.delete();
    end else begin
      // accepted row word
      if (rows.valid && rows.ready) begin
        fold_row({rows.cond_7, rows.cond_6, rows.cond_5, rows.cond_4,
                  rows.cond_3, rows.cond_2, rows.cond_1, rows.cond_0},
                 rows.outcome, rows.last_row);
      end
      // accepted result word
      if (verdicts.valid && verdicts.ready) begin
        got = {verdicts.solution_ok, verdicts.consistency_ok, verdicts.coverage_ok,
               verdicts.total_x, verdicts.total_xy, verdicts.total_y};
        if (due_verdicts.size() == 0) begin
          fail_count++;
          if (shown < 10) begin
            shown++;
            $display("unexpected result word: ok=%b/%b/%b x=%0d xy=%0d y=%0d",
                     got.solution_ok, got.consistency_ok, got.coverage_ok,
                     got.total_x, got.total_xy, got.total_y);
          end
        end else begin
          want = due_verdicts.pop_front();
          if (got.solution_ok !== want.solution_ok ||
              got.consistency_ok !== want.consistency_ok ||
              got.coverage_ok !== want.coverage_ok ||
              got.total_x !== want.total_x ||
              got.total_xy !== want.total_xy ||
              got.total_y !== want.total_y) begin
            fail_count++;
            if (shown < 10) begin
              shown++;
              $display("result mismatch: expected ok=%b/%b/%b x=%0d xy=%0d y=%0d",
                       want.solution_ok, want.consistency_ok, want.coverage_ok,
                       want.total_x, want.total_xy, want.total_y);
              $display("                 actual   ok=%b/%b/%b x=%0d xy=%0d y=%0d",
                       got.solution_ok, got.consistency_ok, got.coverage_ok,
                       got.total_x, got.total_xy, got.total_y);
            end
          end
        end
      end
      // register write on the config bus
      if (psel && penable && pwrite && pready) begin
        idx = reg_idx_t'(paddr[ADDR_W-1 -: IDX_W]);
        unique case (idx) inside
          REG_PAIR_0, REG_PAIR_1, REG_PAIR_2, REG_PAIR_3: begin
            pair_reg[idx[1:0]] = pwdata[PAIR_W-1:0];
          end
          REG_FUZZY_MASK: mask_reg  = pwdata[MASK_W-1:0];
          REG_IMP_COUNT:  count_reg = pwdata[CNT_W-1:0];
          REG_CONS_THR:   cons_reg  = pwdata[IN_W-1:0];
          REG_COV_THR:    cov_reg   = pwdata[IN_W-1:0];
          default: ;
        endcase
      end
    end
    verdicts_due = due_verdicts.size();
  end

endmodule

FILE: sim/fuzzy_solution_consistency_check_tb.sv
`timescale 1ns / 1ps

module fuzzy_solution_consistency_check_tb;
  import fscc_pkg::*;

  localparam int LIMIT = 400000;

  typedef logic [NCOND_MX-1:0][IN_W-1:0] cond_vec_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int                fail_count;
  int                verdicts_due;
  int                cycles = 0;
  int                send_idle = 0;
  int                recv_stall = 0;
  logic [MASK_W-1:0] cur_mask;

  fscc_in_if  rows_if ();
  fscc_out_if verdicts_if ();

  fuzzy_solution_consistency_check i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (rows_if),
    .out_ch  (verdicts_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  fscc_verdict_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rows         (rows_if),
    .verdicts     (verdicts_if),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count   (fail_count),
    .verdicts_due (verdicts_due)
  );

  always #4 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    verdicts_if.ready <= ($urandom_range(99) < recv_stall) ? 1'b0 : 1'b1;
  end

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_idle = 0;  recv_stall = 0;  end
      1: begin send_idle = 71; recv_stall = 0;  end
      2: begin send_idle = 0;  recv_stall = 71; end
      default: begin send_idle = 24; recv_stall = 24; end
    endcase
  endtask

  // apb write: setup then access, bus stays selected for the next write
  task automatic reg_write(reg_idx_t idx, logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
  endtask

  task automatic program_setting(pair_t p0, pair_t p1, pair_t p2, pair_t p3,
                                 logic [MASK_W-1:0] mask, logic [CNT_W-1:0] cnt,
                                 logic [IN_W-1:0] cons, logic [IN_W-1:0] cov);
    reg_write(REG_PAIR_0, DATA_W'(p0));
    reg_write(REG_PAIR_1, DATA_W'(p1));
    reg_write(REG_PAIR_2, DATA_W'(p2));
    reg_write(REG_PAIR_3, DATA_W'(p3));
    reg_write(REG_FUZZY_MASK, DATA_W'(mask));
    reg_write(REG_IMP_COUNT, DATA_W'(cnt));
    reg_write(REG_CONS_THR, DATA_W'(cons));
    reg_write(REG_COV_THR, DATA_W'(cov));
    psel     <= 1'b0;
    penable  <= 1'b0;
    cur_mask = mask;
  endtask

  // one row word, entered and left at a falling edge
  task automatic send_row(cond_vec_t cv, logic [IN_W-1:0] outc, logic last);
    while ($urandom_range(99) < send_idle) begin
      rows_if.valid <= 1'b0;
      @(negedge clk);
    end
    rows_if.cond_0   <= cv[0];
    rows_if.cond_1   <= cv[1];
    rows_if.cond_2   <= cv[2];
    rows_if.cond_3   <= cv[3];
    rows_if.cond_4   <= cv[4];
    rows_if.cond_5   <= cv[5];
    rows_if.cond_6   <= cv[6];
    rows_if.cond_7   <= cv[7];
    rows_if.outcome  <= outc;
    rows_if.last_row <= last;
    rows_if.valid    <= 1'b1;
    do @(posedge clk); while (!rows_if.ready);
    @(negedge clk);
  endtask

  // close a phase: all results back, then let the pipeline empty
  task automatic end_phase();
    rows_if.valid <= 1'b0;
    while (verdicts_due != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  function automatic logic [IN_W-1:0] pick_value(bit fuzzy);
    int r;
    r = $urandom_range(99);
    if (r < 8) return IN_W'($urandom_range(2047));
    if (!fuzzy) return IN_W'($urandom_range(7));
    if (r < 12) return '0;
    if (r < 16) return 11'd1024;
    return IN_W'($urandom_range(1024));
  endfunction

  function automatic logic [IN_W-1:0] pick_outcome();
    int r;
    r = $urandom_range(99);
    if (r < 10) return IN_W'($urandom_range(2047));
    if (r < 15) return 11'd1024;
    if (r < 18) return '0;
    return IN_W'($urandom_range(1024));
  endfunction

  // one data set of random rows, closed by a last row
  task automatic send_set(int len);
    cond_vec_t cv;
    for (int k = 0; k < len; k++) begin
      for (int c = 0; c < NCOND_MX; c++) cv[c] = pick_value(cur_mask[c]);
      send_row(cv, pick_outcome(), (k == len - 1));
    end
  endtask

  // random register setting; low flavors pin the extremes
  task automatic random_setting(int flavor);
    pair_t             p [NUM_PAIR];
    logic [MASK_W-1:0] mask;
    logic [CNT_W-1:0]  cnt;
    logic [IN_W-1:0]   cons;
    logic [IN_W-1:0]   cov;
    for (int pi = 0; pi < NUM_PAIR; pi++) begin
      if ($urandom_range(9) == 0) begin
        p[pi] = PAIR_W'({$urandom, $urandom});
      end else begin
        for (int c = 0; c < 2 * NCOND_MX; c++) begin
          p[pi][CODE_W*c +: CODE_W] = $urandom_range(1) ? CODE_ABSENT
                                                        : CODE_W'($urandom_range(7, 1));
        end
      end
    end
    mask = MASK_W'($urandom_range(255));
    cnt  = ($urandom_range(99) < 80) ? CNT_W'($urandom_range(8, 1))
                                     : CNT_W'($urandom_range(15));
    cons = ($urandom_range(9) == 0) ? IN_W'($urandom_range(2047)) : IN_W'($urandom_range(1024));
    cov  = ($urandom_range(9) == 0) ? IN_W'($urandom_range(2047)) : IN_W'($urandom_range(1024));
    case (flavor)
      0: begin mask = '0; cnt = 4'd1; cons = '0; cov = '0; end
      1: begin mask = '1; cnt = 4'd8; cons = 11'd1024; cov = 11'd1024; end
      2: begin cnt = CNT_W'($urandom_range(15, 9)); cons = 11'd2047; cov = 11'd2047; end
      3: begin cnt = 4'd0; end
      default: ;
    endcase
    program_setting(p[0], p[1], p[2], p[3], mask, cnt, cons, cov);
  endtask

  initial begin
    cond_vec_t cv;
    int        sent;
    int        len;
    rst_n               = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    rows_if.valid       = 1'b0;
    rows_if.cond_0      = '0;
    rows_if.cond_1      = '0;
    rows_if.cond_2      = '0;
    rows_if.cond_3      = '0;
    rows_if.cond_4      = '0;
    rows_if.cond_5      = '0;
    rows_if.cond_6      = '0;
    rows_if.cond_7      = '0;
    rows_if.outcome     = '0;
    rows_if.last_row    = 1'b0;
    cur_mask            = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // fuzzy terms: negation, as-is, clamping above full membership
    set_idling(0);
    program_setting(48'o21, '0, '0, '0, 8'hFF, 4'd1, 11'd1024, 11'd0);
    send_row({8{11'd0}}, 11'd0, 1'b0);
    send_row({8{11'd1024}}, 11'd1024, 1'b0);
    send_row({8{11'd2047}}, 11'd2047, 1'b0);
    cv = '0;
    cv[1] = 11'd1024;
    send_row(cv, 11'd1024, 1'b0);
    cv[0] = 11'd100;
    cv[1] = 11'd900;
    send_row(cv, 11'd500, 1'b1);
    end_phase();

    // crisp level matches across all eight implicants
    set_idling(1);
    program_setting({24'o00000070, 24'o00000001}, {24'o77777777, 24'o33333333},
                    {24'o12345670, 24'o00004000}, {24'o00000002, 24'o00500000},
                    8'h00, 4'd8, 11'd1024, 11'd1024);
    send_row({8{11'd0}}, 11'd1024, 1'b0);
    send_row({8{11'd2}}, 11'd0, 1'b0);
    send_row({8{11'd6}}, 11'd700, 1'b0);
    cv = {8{11'd7}};
    cv[1] = 11'd6;
    send_row(cv, 11'd1024, 1'b0);
    send_row({8{11'd7}}, 11'd300, 1'b0);
    send_row({8{11'd2047}}, 11'd1024, 1'b1);
    end_phase();

    // no implicant, zero denominators
    set_idling(2);
    program_setting(48'o21, '0, '0, '0, 8'hA5, 4'd0, 11'd0, 11'd0);
    send_row({8{11'd512}}, 11'd0, 1'b1);
    send_row({8{11'd512}}, 11'd1024, 1'b1);
    end_phase();

    // empty implicants, count above the maximum, thresholds above full
    set_idling(3);
    program_setting('0, '0, '0, '0, 8'hFF, 4'd15, 11'd2047, 11'd2047);
    send_row({8{11'd0}}, 11'd1024, 1'b0);
    send_row({8{11'd1024}}, 11'd2047, 1'b1);
    end_phase();

    // exact threshold boundary, just met and just missed
    set_idling(0);
    program_setting(48'o2, '0, '0, '0, 8'h01, 4'd1, 11'd512, 11'd1024);
    cv = '0;
    cv[0] = 11'd1024;
    send_row(cv, 11'd512, 1'b1);
    send_row(cv, 11'd511, 1'b1);
    end_phase();

    // random data sets over several settings and idling phases
    for (int ph = 0; ph < 10; ph++) begin
      set_idling(ph % 4);
      random_setting(ph);
      sent = 0;
      while (sent < 125) begin
        len = ($urandom_range(99) < 70) ? $urandom_range(6, 1) : $urandom_range(40, 7);
        send_set(len);
        sent += len;
      end
      end_phase();
    end

    while (verdicts_due != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && verdicts_due == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
